// ===== rtl/cgexp_pkg.sv =====
`default_nettype none

package cgexp_pkg;

   // Panel size in pixels
   localparam int PANEL_WIDTH  = 240;
   localparam int PANEL_HEIGHT = 320;

   // Widths of clipped sizes and of their product
   localparam int CW_W   = $clog2(PANEL_WIDTH + 1);
   localparam int CH_W   = $clog2(PANEL_HEIGHT + 1);
   localparam int PROD_W = CW_W + CH_W;

   // Glyph cell geometry
   localparam int GLYPH_COLS = 5;
   localparam int GLYPH_ROWS = 7;
   localparam int GLYPH_BITS = GLYPH_COLS * GLYPH_ROWS;

   // Action codes
   localparam logic ACT_FILL = 1'b0;
   localparam logic ACT_CHAR = 1'b1;

   typedef struct packed {
      logic        action;
      logic [15:0] x_pos;
      logic [15:0] y_pos;
      logic [15:0] rect_width;
      logic [15:0] rect_height;
      logic [15:0] fg_color;
      logic [15:0] bg_color;
      logic [7:0]  char_code;
      logic [7:0]  scale_factor;
   } req_type;

   typedef struct packed {
      logic [15:0] win_x_start;
      logic [15:0] win_y_start;
      logic [15:0] win_x_end;
      logic [15:0] win_y_end;
      logic [15:0] fill_color;
      logic [16:0] pixel_count;
      logic        last_rect;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load;
      logic emit_first;
      logic emit_dot;
      logic col_end;
      logic emit_flush;
   } ctl_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic fill_action;
      logic flush_done;
   } ctl_status_type;

   // 5x7 font: column 0 in the low 7 bits, row 0 as each column's LSB.
   // Codes missing from the font draw the blank glyph.
   function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [7:0] code);
      logic [39:0] cols;
      case (code)
         8'h30:   cols = 40'h3E_45_49_51_3E;
         8'h31:   cols = 40'h00_40_7F_42_00;
         8'h32:   cols = 40'h46_49_51_61_42;
         8'h33:   cols = 40'h31_4B_45_41_21;
         8'h34:   cols = 40'h10_7F_12_14_18;
         8'h35:   cols = 40'h39_45_45_45_27;
         8'h36:   cols = 40'h30_49_49_4A_3C;
         8'h37:   cols = 40'h03_05_09_71_01;
         8'h38:   cols = 40'h36_49_49_49_36;
         8'h39:   cols = 40'h1E_29_49_49_06;
         8'h41:   cols = 40'h7E_11_11_11_7E;
         8'h43:   cols = 40'h22_41_41_41_3E;
         8'h45:   cols = 40'h41_49_49_49_7F;
         8'h46:   cols = 40'h01_09_09_09_7F;
         8'h48:   cols = 40'h7F_08_08_08_7F;
         8'h49:   cols = 40'h00_41_7F_41_00;
         8'h4C:   cols = 40'h40_40_40_40_7F;
         8'h4D:   cols = 40'h7F_02_0C_02_7F;
         8'h4E:   cols = 40'h7F_10_08_04_7F;
         8'h4F:   cols = 40'h3E_41_41_41_3E;
         8'h50:   cols = 40'h06_09_09_09_7F;
         8'h52:   cols = 40'h46_29_19_09_7F;
         8'h53:   cols = 40'h31_49_49_49_46;
         8'h54:   cols = 40'h01_01_7F_01_01;
         8'h55:   cols = 40'h3F_40_40_40_3F;
         8'h3A:   cols = 40'h00_00_36_36_00;
         8'h2E:   cols = 40'h00_00_60_40_00;
         default: cols = 40'h00_00_00_00_00;
      endcase
      return {cols[38:32], cols[30:24], cols[22:16], cols[14:8], cols[6:0]};
   endfunction

endpackage

`default_nettype wire

// ===== rtl/cgexp_ctrl.sv =====
`default_nettype none

module cgexp_ctrl (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire cgexp_pkg::ctl_status_type status,
   output cgexp_pkg::ctl_cmd_type         cmd
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_FIRST = 5'b00010,
      S_SCAN  = 5'b00100,
      S_FLUSH = 5'b01000,
      S_DRAIN = 5'b10000
   } ctl_state_type;

   ctl_state_type state_ff, state_in;
   logic [2:0]    row_ff, row_in;
   logic [2:0]    col_ff, col_in;
   logic          row_last;
   logic          col_last;

   assign busy     = (state_ff != S_IDLE);
   assign row_last = (row_ff == 3'(cgexp_pkg::GLYPH_ROWS - 1));
   assign col_last = (col_ff == 3'(cgexp_pkg::GLYPH_COLS - 1));

   // Next state, dot counters and datapath commands
   always_comb begin
      state_in       = state_ff;
      row_in         = row_ff;
      col_in         = col_ff;
      cmd            = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_FIRST;
            end
         end
         S_FIRST: begin
            cmd.emit_first = 1'b1;
            row_in         = 3'd0;
            col_in         = 3'd0;
            if (status.fill_action) begin
               state_in = S_FLUSH;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.emit_dot = 1'b1;
            cmd.col_end  = row_last;
            if (row_last) begin
               row_in = 3'd0;
               if (col_last) begin
                  col_in   = 3'd0;
                  state_in = S_FLUSH;
               end else begin
                  col_in = col_ff + 3'd1;
               end
            end else begin
               row_in = row_ff + 3'd1;
            end
         end
         S_FLUSH: begin
            cmd.emit_flush = 1'b1;
            state_in       = S_DRAIN;
         end
         S_DRAIN: begin
            if (status.flush_done) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         row_ff   <= 3'd0;
         col_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         row_ff   <= row_in;
         col_ff   <= col_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_accept_to_first: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == S_FIRST))
      else $error("accepted command did not enter first-record state");
   a_row_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= 3'(cgexp_pkg::GLYPH_ROWS - 1)) && (col_ff <= 3'(cgexp_pkg::GLYPH_COLS - 1)))
      else $error("glyph dot counters out of range");
   a_flush_after_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && row_last && col_last) |=> (state_ff == S_FLUSH))
      else $error("scan end did not lead to flush");
`endif

endmodule

`default_nettype wire

// ===== rtl/cgexp_datapath.sv =====
`default_nettype none

module cgexp_datapath (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cgexp_pkg::req_type        req_data,
   input  wire cgexp_pkg::ctl_cmd_type    cmd,
   output cgexp_pkg::ctl_status_type      status,
   output logic                           rsp_strobe,
   output cgexp_pkg::rsp_type             rsp_data
);

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] w;
      logic [15:0] h;
      logic [15:0] color;
   } cand_type;

   typedef struct packed {
      logic [15:0]                 x;
      logic [15:0]                 y;
      logic [cgexp_pkg::CW_W-1:0] wc;
      logic [cgexp_pkg::CH_W-1:0] hc;
      logic [15:0]                 color;
   } clip_type;

   // Command, glyph and position registers
   cgexp_pkg::req_type                cmd_ff;
   logic [cgexp_pkg::GLYPH_BITS-1:0]  glyph_ff;
   logic [15:0]                       px_ff;
   logic [15:0]                       py_ff;

   // Candidate stage
   cand_type cand_ff, cand_in;
   logic     cand_valid_ff, cand_valid_in;
   logic     cand_flush_ff, cand_flush_in;

   // Clip stage
   clip_type clip_ff, clip_in;
   logic     clip_valid_ff, clip_valid_in;
   logic     clip_flush_ff;
   logic [cgexp_pkg::CW_W-1:0] room_x;
   logic [cgexp_pkg::CH_W-1:0] room_y;
   logic     on_panel;

   // Pending record and output
   cgexp_pkg::rsp_type pend_ff, pend_in;
   logic               have_ff, have_in;
   cgexp_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [cgexp_pkg::PROD_W-1:0]  prod;
   logic [cgexp_pkg::PROD_W+16:0] prod_ext;

   logic [15:0] scale16;

   assign scale16            = 16'(cmd_ff.scale_factor);
   assign status.fill_action = (cmd_ff.action == cgexp_pkg::ACT_FILL);
   assign status.flush_done  = clip_flush_ff;

   // Latch the command; walk glyph dots column by column
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff   <= req_data;
         px_ff    <= req_data.x_pos;
         py_ff    <= req_data.y_pos;
         glyph_ff <= cgexp_pkg::glyph_bits(req_data.char_code);
      end else if (cmd.emit_dot) begin
         glyph_ff <= glyph_ff >> 1;
         if (cmd.col_end) begin
            py_ff <= cmd_ff.y_pos;
            px_ff <= px_ff + scale16;
         end else begin
            py_ff <= py_ff + scale16;
         end
      end
   end

   // Candidate rectangle for this cycle
   always_comb begin
      cand_in       = cand_ff;
      cand_valid_in = 1'b0;
      cand_flush_in = cmd.emit_flush;
      if (cmd.emit_first) begin
         cand_valid_in = 1'b1;
         cand_in.x     = cmd_ff.x_pos;
         cand_in.y     = cmd_ff.y_pos;
         if (cmd_ff.action == cgexp_pkg::ACT_FILL) begin
            cand_in.w     = cmd_ff.rect_width;
            cand_in.h     = cmd_ff.rect_height;
            cand_in.color = cmd_ff.fg_color;
         end else begin
            cand_in.w     = (scale16 << 2) + scale16;
            cand_in.h     = (scale16 << 3) - scale16;
            cand_in.color = cmd_ff.bg_color;
         end
      end else if (cmd.emit_dot) begin
         cand_valid_in = glyph_ff[0];
         cand_in.x     = px_ff;
         cand_in.y     = py_ff;
         cand_in.w     = scale16;
         cand_in.h     = scale16;
         cand_in.color = cmd_ff.fg_color;
      end
   end

   // Clip to the panel
   always_comb begin
      on_panel = (cand_ff.x < 16'(cgexp_pkg::PANEL_WIDTH)) &&
                 (cand_ff.y < 16'(cgexp_pkg::PANEL_HEIGHT));
      room_x   = cgexp_pkg::CW_W'(cgexp_pkg::PANEL_WIDTH) - cgexp_pkg::CW_W'(cand_ff.x);
      room_y   = cgexp_pkg::CH_W'(cgexp_pkg::PANEL_HEIGHT) - cgexp_pkg::CH_W'(cand_ff.y);
      clip_in.x     = cand_ff.x;
      clip_in.y     = cand_ff.y;
      clip_in.color = cand_ff.color;
      clip_in.wc    = (cand_ff.w > 16'(room_x)) ? room_x : cgexp_pkg::CW_W'(cand_ff.w);
      clip_in.hc    = (cand_ff.h > 16'(room_y)) ? room_y : cgexp_pkg::CH_W'(cand_ff.h);
      clip_valid_in = cand_valid_ff && on_panel;
   end

   // Pixel count of the clipped rectangle
   assign prod     = cgexp_pkg::PROD_W'(clip_ff.wc) * cgexp_pkg::PROD_W'(clip_ff.hc);
   assign prod_ext = {17'd0, prod};

   // Hold one record back so the final one can be flagged
   always_comb begin
      pend_in               = pend_ff;
      have_in               = have_ff;
      rsp_strobe_in         = 1'b0;
      rsp_data_in           = pend_ff;
      rsp_data_in.last_rect = 1'b0;
      if (clip_valid_ff) begin
         rsp_strobe_in       = have_ff;
         have_in             = 1'b1;
         pend_in.win_x_start = clip_ff.x;
         pend_in.win_y_start = clip_ff.y;
         pend_in.win_x_end   = clip_ff.x + 16'(clip_ff.wc) - 16'd1;
         pend_in.win_y_end   = clip_ff.y + 16'(clip_ff.hc) - 16'd1;
         pend_in.fill_color  = clip_ff.color;
         pend_in.pixel_count = prod_ext[16:0];
         pend_in.last_rect   = 1'b0;
      end else if (clip_flush_ff) begin
         rsp_strobe_in         = have_ff;
         rsp_data_in.last_rect = 1'b1;
         have_in               = 1'b0;
      end
   end

   // Stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_valid_ff <= 1'b0;
         cand_flush_ff <= 1'b0;
         clip_valid_ff <= 1'b0;
         clip_flush_ff <= 1'b0;
         have_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         cand_valid_ff <= cand_valid_in;
         cand_flush_ff <= cand_flush_in;
         clip_valid_ff <= clip_valid_in;
         clip_flush_ff <= cand_flush_ff;
         have_ff       <= have_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      clip_ff     <= clip_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

`ifndef NO_ASSERTIONS
   a_strobe_has_record: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> $past(have_ff))
      else $error("result transfer without a pending record");
   a_flush_alone: assert property (@(posedge clock) disable iff (reset)
      !(clip_valid_ff && clip_flush_ff))
      else $error("flush token collided with a record");
   a_flush_empties: assert property (@(posedge clock) disable iff (reset)
      clip_flush_ff |=> !have_ff)
      else $error("pending record left after flush");
`endif

endmodule

`default_nettype wire

// ===== rtl/clipped_rect_and_glyph_expander.sv =====
`default_nettype none
// Fill command: busy through the first-record, flush and drain states; its record, flagged last, is on rsp
// once the flush token has passed the clip stage. Character command: busy through one background
// step, one step per glyph dot, a flush step and the drain; a new command is accepted only once busy is low.
// The dot scan visits one glyph bit per cycle; records come out one per cycle at most.
// Synchronous active-high reset returns the controller to idle and clears all strobes.
// The receiver cannot stall: each record shows on rsp for exactly one cycle.

module clipped_rect_and_glyph_expander (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire cgexp_pkg::req_type req_data,
   output logic                    rsp_strobe,
   output cgexp_pkg::rsp_type      rsp_data
);

   cgexp_pkg::ctl_cmd_type    cmd;
   cgexp_pkg::ctl_status_type status;

   cgexp_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .status (status),
      .cmd    (cmd)
   );

   cgexp_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

`default_nettype wire
